FILE: rtl/last_value_load_predictor_defines.svh
// Assertion macros used by the checker of the load value predictor.
`ifndef LAST_VALUE_LOAD_PREDICTOR_DEFINES_SVH
`define LAST_VALUE_LOAD_PREDICTOR_DEFINES_SVH

// Clocked on clk, disabled while arst_n is low.
`define LVP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked on clk, checked through reset as well.
`define LVP_ASSERT_NORST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/lvp_pkg.sv
// Types and constants of the last value load predictor.
package lvp_pkg;

	localparam int DATA_W = 64;
	localparam int CFG_W = 11;
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	typedef struct packed {
		logic [DATA_W-1:0] load_pc;
		logic [DATA_W-1:0] actual_value;
		logic              read_ok;
	} load_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] predicted_value;
		logic              table_hit;
		logic              prediction_correct;
		logic [DATA_W-1:0] total_predictions;
		logic [DATA_W-1:0] correct_predictions;
	} result_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} lvp_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} lvp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} lvp_sts_t;

endpackage

FILE: rtl/lvp_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
interface lvp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lvp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module lvp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

FILE: rtl/lvp_ctrl.sv
// Controller state machine: accept, scan, write back.
module lvp_ctrl import lvp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_read_ok,
	output logic     in_ready,
	output lvp_cmd_t cmd,
	input  lvp_sts_t sts
);
	lvp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				// a failed read is taken and dropped
				if (in_valid && in_read_ok) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				// hold until the result register can take the new result
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

FILE: rtl/lvp_datapath.sv
// Datapath: table RAM, scan pointer, fill and FIFO pointers, tallies, result register.
module lvp_datapath import lvp_pkg::*; #(
	parameter int ENTRIES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	input  load_item_t       item,
	input  lvp_cmd_t         cmd,
	output lvp_sts_t         sts,
	output result_item_t     result,
	output logic             result_valid,
	input  logic             result_ready
);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int RAM_W = 2 * DATA_W;
	localparam logic [31:0] ENTRIES_W = 32'(ENTRIES);
	localparam logic [CNT_W-1:0] LIMIT_RESET =
		(32'(CFG_RESET) > ENTRIES_W) ? CNT_W'(ENTRIES) : CNT_W'(CFG_RESET);

	logic [CNT_W-1:0]  limit_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	logic              cmp_vld_q;
	logic [IDX_W-1:0]  cmp_idx_q;
	logic              hit_q;
	logic [IDX_W-1:0]  slot_q;
	logic [DATA_W-1:0] pred_q;
	logic [DATA_W-1:0] pc_q;
	logic [DATA_W-1:0] act_q;
	logic [DATA_W-1:0] total_q;
	logic [DATA_W-1:0] correct_q;
	result_item_t      result_q;
	logic              result_valid_q;

	logic [31:0]       cfg_wide;
	logic [31:0]       lim_next;
	logic              rd_more;
	logic              match;
	logic [RAM_W-1:0]  ram_rd_data;
	logic [DATA_W-1:0] ram_key;
	logic [DATA_W-1:0] ram_val;
	logic              fill_room;
	logic [IDX_W-1:0]  old_sel;
	logic [CNT_W-1:0]  old_inc;
	logic [IDX_W-1:0]  old_next;
	logic [IDX_W-1:0]  wr_slot;
	logic              correct;

	// clamp the limit into 1..ENTRIES once, at the write
	assign cfg_wide = 32'(cfg_wr_data);
	always_comb begin
		priority if (cfg_wide == 32'd0) begin
			lim_next = 32'd1;
		end else if (cfg_wide > ENTRIES_W) begin
			lim_next = ENTRIES_W;
		end else begin
			lim_next = cfg_wide;
		end
	end

	// entries fill in slot order, so slots below fill_q are exactly the valid ones
	assign rd_more = rd_cnt_q < fill_q;
	assign ram_key = ram_rd_data[RAM_W-1:DATA_W];
	assign ram_val = ram_rd_data[DATA_W-1:0];
	assign match   = cmp_vld_q && (ram_key == pc_q);

	assign sts.scan_done = match || (!cmp_vld_q && !rd_more);
	assign sts.out_free  = !result_valid_q || result_ready;

	assign fill_room = fill_q < limit_q;
	assign old_sel   = (CNT_W'(oldest_q) < limit_q) ? oldest_q : '0;
	assign old_inc   = CNT_W'(old_sel) + CNT_W'(1);
	assign old_next  = (old_inc >= limit_q) ? '0 : IDX_W'(old_inc);
	assign wr_slot   = hit_q ? slot_q : (fill_room ? IDX_W'(fill_q) : old_sel);
	assign correct   = pred_q == act_q;

	lvp_ram #(
		.WIDTH (RAM_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (cmd.commit),
		.wr_addr (wr_slot),
		.wr_data ({pc_q, act_q}),
		.rd_en   (cmd.scan && rd_more),
		.rd_addr (IDX_W'(rd_cnt_q)),
		.rd_data (ram_rd_data)
	);

	// control and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q        <= LIMIT_RESET;
			fill_q         <= '0;
			oldest_q       <= '0;
			rd_cnt_q       <= '0;
			cmp_vld_q      <= 1'b0;
			hit_q          <= 1'b0;
			total_q        <= '0;
			correct_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q  <= CNT_W'(lim_next);
				fill_q   <= '0;
				oldest_q <= '0;
			end
			if (cmd.start) begin
				rd_cnt_q  <= '0;
				cmp_vld_q <= 1'b0;
				hit_q     <= 1'b0;
			end
			if (cmd.scan) begin
				cmp_vld_q <= rd_more;
				if (rd_more) begin
					rd_cnt_q <= rd_cnt_q + CNT_W'(1);
				end
				if (match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (!hit_q) begin
					if (fill_room) begin
						fill_q <= fill_q + CNT_W'(1);
					end else begin
						oldest_q <= old_next;
					end
				end
				total_q   <= total_q + DATA_W'(1);
				correct_q <= correct_q + DATA_W'(correct);
			end
			if (cmd.commit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pc_q   <= item.load_pc;
			act_q  <= item.actual_value;
			pred_q <= '0;
		end
		if (cmd.scan) begin
			cmp_idx_q <= IDX_W'(rd_cnt_q);
			if (match) begin
				slot_q <= cmp_idx_q;
				pred_q <= ram_val;
			end
		end
		if (cmd.commit) begin
			result_q.predicted_value     <= pred_q;
			result_q.table_hit           <= hit_q;
			result_q.prediction_correct  <= correct;
			result_q.total_predictions   <= total_q + DATA_W'(1);
			result_q.correct_predictions <= correct_q + DATA_W'(correct);
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;
endmodule

FILE: rtl/last_value_load_predictor.sv
// Scan: a transferred load is compared against the filled table slots up to the first match,
//   all of them on a miss and none on an empty table; the scan reads one table slot per cycle.
// Loads: one load at a time; the next is taken only after the write-back of the last, and a
//   result left waiting holds the write-back. A read_ok low load is taken and dropped.
// Reset (arst_n low, asynchronous): table empty, tallies zero, limit 1024
//   clamped to ENTRIES; no clearing pass, the block takes loads at once.
module last_value_load_predictor import lvp_pkg::*; #(
	parameter int ENTRIES = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data,
	lvp_stream_if.sink       load_ch,
	lvp_stream_if.source     result_ch
);
	// Structure
	// - lvp_ctrl sequences each load: IDLE takes a transfer, SCAN walks the
	//   filled slots of the table RAM, WRITE trains the table and loads the
	//   result register.
	// - lvp_datapath owns the table RAM ({pc, value} per slot), the scan pointer,
	//   the fill count and FIFO eviction pointer, the tallies and the result
	//   register.
	// Slots are filled in order 0, 1, 2, ... after every reset or limit write, so
	// "slot below fill count" stands in for a per-entry valid bit.

	lvp_cmd_t cmd;
	lvp_sts_t sts;
	logic     in_ready;

	lvp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (load_ch.valid),
		.in_read_ok (load_ch.data.read_ok),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.sts        (sts)
	);

	// The result register parts the two sides: a new load transfers while the
	// last result still waits to be taken.
	lvp_datapath #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item         (load_ch.data),
		.cmd          (cmd),
		.sts          (sts),
		.result       (result_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready)
	);

	assign load_ch.ready = in_ready;
endmodule

FILE: rtl/lvp_checker.sv
// Port level checks of the predictor result stream, bound to the top level.
`include "last_value_load_predictor_defines.svh"

module lvp_checker import lvp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [DATA_W-1:0] predicted_value,
	input logic              table_hit,
	input logic              prediction_correct,
	input logic [DATA_W-1:0] total_predictions,
	input logic [DATA_W-1:0] correct_predictions
);
	logic              seen_q;
	logic [DATA_W-1:0] last_total_q;
	logic [DATA_W-1:0] last_correct_q;
	logic              res_xfer;

	assign res_xfer = res_valid && res_ready;

	// remember the tallies of the last transferred result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q         <= 1'b0;
			last_total_q   <= '0;
			last_correct_q <= '0;
		end else if (res_xfer) begin
			seen_q         <= 1'b1;
			last_total_q   <= total_predictions;
			last_correct_q <= correct_predictions;
		end
	end

	`LVP_ASSERT(a_result_hold, res_valid && !res_ready |=> res_valid, "result dropped")
	`LVP_ASSERT(a_miss_zero, res_valid && !table_hit |-> predicted_value == '0, "miss not zero")
	`LVP_ASSERT(a_total_step, res_xfer && seen_q |-> total_predictions == last_total_q + DATA_W'(1), "total step")
	`LVP_ASSERT(a_correct_step, res_xfer && seen_q |-> correct_predictions == last_correct_q + DATA_W'(prediction_correct), "correct step")
	`LVP_ASSERT_NORST(a_reset_quiet, !arst_n |-> !res_valid, "result valid in reset")
endmodule

bind last_value_load_predictor lvp_checker u_lvp_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.res_valid           (result_ch.valid),
	.res_ready           (result_ch.ready),
	.predicted_value     (result_ch.data.predicted_value),
	.table_hit           (result_ch.data.table_hit),
	.prediction_correct  (result_ch.data.prediction_correct),
	.total_predictions   (result_ch.data.total_predictions),
	.correct_predictions (result_ch.data.correct_predictions)
);
